FILE: src/cpb_pkg.sv
`timescale 1ns / 1ps

package cpb_pkg;

    // fixed field and register geometry
    localparam int IN_W       = 32;
    localparam int RES_W      = 32;
    localparam int REG_W      = 64;
    localparam int HALF_W     = 32;
    localparam int NUM_REGS   = 6;
    localparam int IDX_W      = 3;

    // fixed-point alignment
    localparam int FRAC_SHIFT = 16;
    localparam int TERM_SHIFT = 32;

    // multiplier slicing and depth
    localparam int MUL_CHUNK  = 32;
    localparam int MUL_LAT    = 4;

    typedef enum logic
    {
        CMD_PROJECT     = 1'b0,
        CMD_BACKPROJECT = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        STATUS_OK   = 2'd0,
        STATUS_ZERO = 2'd1,
        STATUS_SAT  = 2'd2
    } status_t;

    typedef struct packed
    {
        cmd_t                    cmd;
        logic signed [IN_W-1:0]  coord_a;
        logic signed [IN_W-1:0]  coord_b;
        logic signed [IN_W-1:0]  coord_c;
        logic signed [IN_W-1:0]  coord_w;
    } req_t;

    typedef struct packed
    {
        logic signed [RES_W-1:0] result_a;
        logic signed [RES_W-1:0] result_b;
        status_t                 status;
    } rsp_t;

endpackage

FILE: src/cpb_mul.sv
`timescale 1ns / 1ps

module cpb_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic                   clk,
    input  logic signed [A_W-1:0]  a,
    input  logic signed [B_W-1:0]  b,
    output logic signed [A_W+B_W-1:0] p
);
    import cpb_pkg::*;

    localparam int CH  = MUL_CHUNK;
    localparam int NA  = (A_W + CH - 1) / CH;
    localparam int NB  = (B_W + CH - 1) / CH;
    localparam int RW  = (NB + 1) * CH;
    localparam int TW  = (NA + NB) * CH;
    localparam int PW  = A_W + B_W;

    logic [A_W-1:0]     am_next;
    logic [B_W-1:0]     bm_next;
    logic [NA*CH-1:0]   am_reg;
    logic [NB*CH-1:0]   bm_reg;
    logic               neg1_reg, neg2_reg, neg3_reg;
    logic [2*CH-1:0]    pp_reg [NA][NB];
    logic [RW-1:0]      row_next [NA];
    logic [RW-1:0]      row_reg [NA];
    logic [TW-1:0]      tot_next;
    logic [PW-1:0]      mag;
    logic signed [PW-1:0] p_reg;

    // magnitudes
    always_comb
    begin
        am_next = a[A_W-1] ? ($unsigned(~a) + 1'b1) : $unsigned(a);
        bm_next = b[B_W-1] ? ($unsigned(~b) + 1'b1) : $unsigned(b);
    end

    always_ff @(posedge clk)
    begin
        am_reg   <= (NA*CH)'(am_next);
        bm_reg   <= (NB*CH)'(bm_next);
        neg1_reg <= a[A_W-1] ^ b[B_W-1];
    end

    // 32x32 partial products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_reg[i][j] <= am_reg[i*CH +: CH] * bm_reg[j*CH +: CH];
            end
        end
        neg2_reg <= neg1_reg;
    end

    // row sums
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (CH * j));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_reg[i] <= row_next[i];
        end
        neg3_reg <= neg2_reg;
    end

    // final sum and sign
    always_comb
    begin
        tot_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            tot_next = tot_next + (TW'(row_reg[i]) << (CH * i));
        end
        mag = PW'(tot_next);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= neg3_reg ? -$signed(mag) : $signed(mag);
    end

    assign p = p_reg;

endmodule

FILE: src/cpb_div.sv
`timescale 1ns / 1ps

module cpb_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 64,
    parameter int QUO_W = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     vld,
    input  logic                     zero,
    input  logic signed [NUM_W-1:0]  num_a,
    input  logic signed [NUM_W-1:0]  num_b,
    input  logic signed [DEN_W-1:0]  den,
    output logic                     done,
    output cpb_pkg::rsp_t            rsp
);
    import cpb_pkg::*;

    localparam int W  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
    localparam int NS = QUO_W + 1;
    localparam logic [QUO_W-1:0] Q_MIN = {1'b1, {(QUO_W-1){1'b0}}};
    localparam logic [QUO_W-1:0] Q_MAX = ~Q_MIN;

    logic signed [NUM_W-1:0] num [2];
    logic                    vld_reg  [NS];
    logic                    zero_reg [NS];
    logic [DEN_W-1:0]        dm_reg   [NS];
    logic [NUM_W-1:0]        r_reg    [NS][2];
    logic [QUO_W-1:0]        q_reg    [NS][2];
    logic                    neg_reg  [NS][2];
    logic                    ovf_reg  [NS][2];
    logic [QUO_W-1:0]        val [2];
    logic                    sat [2];
    logic [RES_W-1:0]        fit [2];
    rsp_t                    rsp_next;
    rsp_t                    rsp_reg;
    logic                    done_reg;

    assign num[0] = num_a;
    assign num[1] = num_b;

    // stage 0: magnitudes and quotient signs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        dm_reg[0]   <= den[DEN_W-1] ? ($unsigned(~den) + 1'b1) : $unsigned(den);
        zero_reg[0] <= zero;
        for (int l = 0; l < 2; l++)
        begin
            r_reg[0][l]   <= num[l][NUM_W-1] ? ($unsigned(~num[l]) + 1'b1)
                                             : $unsigned(num[l]);
            neg_reg[0][l] <= num[l][NUM_W-1] ^ den[DEN_W-1];
            q_reg[0][l]   <= '0;
            ovf_reg[0][l] <= 1'b0;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 1; k < NS; k++)
    begin : g_step
        localparam int SH = QUO_W - k;

        logic [W:0]       diff   [2];
        logic [NUM_W-1:0] r_next [2];
        logic [QUO_W-1:0] q_next [2];
        logic             ovf_next [2];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                diff[l]   = {1'b0, W'(r_reg[k-1][l])} - {1'b0, W'(dm_reg[k-1]) << SH};
                r_next[l] = diff[l][W] ? r_reg[k-1][l] : NUM_W'(diff[l][W-1:0]);
                q_next[l] = q_reg[k-1][l];
                q_next[l][SH] = ~diff[l][W];
                // quotient would not fit in the result width
                ovf_next[l] = ovf_reg[k-1][l]
                            | ((k == 1)
                               && (W'(r_reg[k-1][l]) >= (W'(dm_reg[k-1]) << QUO_W)));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            dm_reg[k]   <= dm_reg[k-1];
            zero_reg[k] <= zero_reg[k-1];
            for (int l = 0; l < 2; l++)
            begin
                r_reg[k][l]   <= r_next[l];
                q_reg[k][l]   <= q_next[l];
                neg_reg[k][l] <= neg_reg[k-1][l];
                ovf_reg[k][l] <= ovf_next[l];
            end
        end
    end

    // sign and clamp
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (ovf_reg[NS-1][l])
            begin
                sat[l] = 1'b1;
                val[l] = neg_reg[NS-1][l] ? Q_MIN : Q_MAX;
            end
            else if (neg_reg[NS-1][l])
            begin
                sat[l] = q_reg[NS-1][l] > Q_MIN;
                val[l] = sat[l] ? Q_MIN : (~q_reg[NS-1][l] + 1'b1);
            end
            else
            begin
                sat[l] = q_reg[NS-1][l] > Q_MAX;
                val[l] = sat[l] ? Q_MAX : q_reg[NS-1][l];
            end
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_fit
        if (QUO_W >= RES_W)
        begin : g_cut
            assign fit[l] = val[l][RES_W-1:0];
        end
        else
        begin : g_pad
            assign fit[l] = {{(RES_W-QUO_W){1'b0}}, val[l]};
        end
    end

    always_comb
    begin
        if (zero_reg[NS-1])
        begin
            rsp_next.result_a = '0;
            rsp_next.result_b = '0;
            rsp_next.status   = STATUS_ZERO;
        end
        else
        begin
            rsp_next.result_a = $signed(fit[0]);
            rsp_next.result_b = $signed(fit[1]);
            rsp_next.status   = (sat[0] || sat[1]) ? STATUS_SAT : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

FILE: src/camera_project_and_plane_backproject.sv
`timescale 1ns / 1ps
// channel    | ports                          | handshake
// -----------+--------------------------------+-----------------------------------
// request    | start, busy, req               | taken when start && !busy
// result     | done, rsp                      | one-cycle strobe, no backpressure
// config     | wr_en, wr_idx, wr_data         | written on any edge with wr_en
//
// one request per cycle; busy never rises
// from request to done: the request register, three multiplier layers
//   with a sum stage after each, a mux stage, then the restoring divider
//   at one quotient bit per stage
// rst_n clears the matrix registers and all valid bits; payload is not reset
// results are never held back: done fires exactly once per request

module camera_project_and_plane_backproject #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  cpb_pkg::req_t               req,
    output logic                        done,
    output cpb_pkg::rsp_t               rsp,
    input  logic                        wr_en,
    input  logic [cpb_pkg::IDX_W-1:0]   wr_idx,
    input  logic [cpb_pkg::REG_W-1:0]   wr_data
);
    import cpb_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int KW  = COEF_WIDTH;
    localparam int PW  = CW + KW;            // coord * coef, Q.28
    localparam int SW  = PW + 2;             // sum of four products
    localparam int AW  = PW + 1;             // a, b, c, d, g terms
    localparam int EW  = AW + CW + 2;        // right-hand side e, f, Q.44
    localparam int DW  = 2 * AW + 1;         // determinant, Q.56
    localparam int NW  = EW + AW + 1;        // Cramer numerators
    localparam int TOT = 3 * MUL_LAT + 5;    // valid bits ahead of the divider

    typedef struct packed
    {
        cmd_t                cmd;
        logic signed [CW-1:0] z;
    } d1_t;

    typedef struct packed
    {
        cmd_t                cmd;
        logic signed [CW-1:0] z;
        logic signed [SW-1:0] n0;
        logic signed [SW-1:0] n1;
        logic signed [SW-1:0] n2;
        logic signed [AW-1:0] a;
        logic signed [AW-1:0] b;
        logic signed [AW-1:0] c;
        logic signed [AW-1:0] d;
        logic signed [AW-1:0] g0;
        logic signed [AW-1:0] g1;
        logic signed [EW-1:0] he;
        logic signed [EW-1:0] hf;
    } s1_t;

    typedef struct packed
    {
        cmd_t                cmd;
        logic signed [SW-1:0] n0;
        logic signed [SW-1:0] n1;
        logic signed [SW-1:0] n2;
        logic signed [AW-1:0] a;
        logic signed [AW-1:0] b;
        logic signed [AW-1:0] c;
        logic signed [AW-1:0] d;
        logic signed [EW-1:0] e;
        logic signed [EW-1:0] f;
    } s2_t;

    typedef struct packed
    {
        cmd_t                cmd;
        logic signed [SW-1:0] n0;
        logic signed [SW-1:0] n1;
        logic signed [SW-1:0] n2;
        logic signed [DW-1:0] det;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
    } s3_t;

    // matrix registers, to be written only while idle; the block itself does not enforce this
    logic [REG_W-1:0]     cfg_reg [NUM_REGS];
    logic signed [KW-1:0] coef [3][4];

    // request capture and valid pipeline
    req_t                 in_reg;
    logic [TOT-1:0]       vld_reg;
    logic signed [CW-1:0] cx [4];

    // multiplier layers
    logic signed [CW-1:0] op_x [12];
    logic signed [KW-1:0] op_k [12];
    logic signed [PW-1:0] m1 [12];
    logic signed [AW+CW-1:0] m2 [2];
    logic signed [2*AW-1:0]  m_ad, m_bc;
    logic signed [EW+AW-1:0] m_ed, m_fb, m_fa, m_ec;

    d1_t                  d1_reg [MUL_LAT];
    s1_t                  s1_next, s1_reg;
    s1_t                  d2_reg [MUL_LAT];
    s2_t                  s2_next, s2_reg;
    s2_t                  d3_reg [MUL_LAT];
    s3_t                  s3_next, s3_reg;

    // divider operands
    logic signed [DW-1:0] den_next, den_reg;
    logic signed [NW-1:0] numx_next, numx_reg;
    logic signed [NW-1:0] numy_next, numy_reg;
    logic                 zero_next, zero_reg;

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            // indexes past the last register are dropped
            for (int i = 0; i < NUM_REGS; i++)
            begin
                if (wr_idx == IDX_W'(i))
                begin
                    cfg_reg[i] <= wr_data;
                end
            end
        end
    end

    // two coefficients per register, even column in the low half
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar k = 0; k < 4; k++)
        begin : g_col
            assign coef[r][k] = cfg_reg[r*2 + k/2][HALF_W*(k%2) +: KW];
        end
    end

    // ---------------------------------------------------------------
    // request capture
    // ---------------------------------------------------------------
    assign busy = 1'b0;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[TOT-2:0], start};
        end
    end

    // coordinates come from the low bits of each field; a wider format
    // sees the field as non-negative
    if (CW <= IN_W)
    begin : g_coord_cut
        assign cx[0] = in_reg.coord_a[CW-1:0];
        assign cx[1] = in_reg.coord_b[CW-1:0];
        assign cx[2] = in_reg.coord_c[CW-1:0];
        assign cx[3] = in_reg.coord_w[CW-1:0];
    end
    else
    begin : g_coord_pad
        assign cx[0] = {{(CW-IN_W){1'b0}}, in_reg.coord_a};
        assign cx[1] = {{(CW-IN_W){1'b0}}, in_reg.coord_b};
        assign cx[2] = {{(CW-IN_W){1'b0}}, in_reg.coord_c};
        assign cx[3] = {{(CW-IN_W){1'b0}}, in_reg.coord_w};
    end

    // ---------------------------------------------------------------
    // layer 1: twelve coord * coef products
    // project uses all twelve as P * X; back-project uses the first
    // eight as x * row 2 and y * row 2
    // ---------------------------------------------------------------
    for (genvar j = 0; j < 12; j++)
    begin : g_l1
        if (j >= 4 && j < 8)
        begin : g_y
            assign op_x[j] = (in_reg.cmd == CMD_BACKPROJECT) ? cx[1] : cx[j%4];
        end
        else
        begin : g_x
            assign op_x[j] = (in_reg.cmd == CMD_BACKPROJECT) ? cx[0] : cx[j%4];
        end
        assign op_k[j] = (in_reg.cmd == CMD_BACKPROJECT) ? coef[2][j%4] : coef[j/4][j%4];

        cpb_mul #(
            .A_W (CW),
            .B_W (KW)
        ) u_mul (
            .clk (clk),
            .a   (op_x[j]),
            .b   (op_k[j]),
            .p   (m1[j])
        );
    end

    // carry cmd and plane height alongside layer 1
    always_ff @(posedge clk)
    begin
        d1_reg[0].cmd <= in_reg.cmd;
        d1_reg[0].z   <= cx[2];
        for (int i = 1; i < MUL_LAT; i++)
        begin
            d1_reg[i] <= d1_reg[i-1];
        end
    end

    // sums after layer 1
    always_comb
    begin
        s1_next.cmd = d1_reg[MUL_LAT-1].cmd;
        s1_next.z   = d1_reg[MUL_LAT-1].z;
        // project dot products
        s1_next.n0  = SW'(m1[0]) + SW'(m1[1]) + SW'(m1[2])  + SW'(m1[3]);
        s1_next.n1  = SW'(m1[4]) + SW'(m1[5]) + SW'(m1[6])  + SW'(m1[7]);
        s1_next.n2  = SW'(m1[8]) + SW'(m1[9]) + SW'(m1[10]) + SW'(m1[11]);
        // back-project 2x2 system, Q.28
        s1_next.a   = AW'(m1[0]) - (AW'(coef[0][0]) <<< FRAC_SHIFT);
        s1_next.b   = AW'(m1[1]) - (AW'(coef[0][1]) <<< FRAC_SHIFT);
        s1_next.c   = AW'(m1[4]) - (AW'(coef[1][0]) <<< FRAC_SHIFT);
        s1_next.d   = AW'(m1[5]) - (AW'(coef[1][1]) <<< FRAC_SHIFT);
        s1_next.g0  = AW'(m1[2]) - (AW'(coef[0][2]) <<< FRAC_SHIFT);
        s1_next.g1  = AW'(m1[6]) - (AW'(coef[1][2]) <<< FRAC_SHIFT);
        // constant parts of the right-hand side, Q.44
        s1_next.he  = (EW'(coef[0][3]) <<< TERM_SHIFT) - (EW'(m1[3]) <<< FRAC_SHIFT);
        s1_next.hf  = (EW'(coef[1][3]) <<< TERM_SHIFT) - (EW'(m1[7]) <<< FRAC_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // ---------------------------------------------------------------
    // layer 2: plane height terms g * z
    // ---------------------------------------------------------------
    cpb_mul #(
        .A_W (AW),
        .B_W (CW)
    ) u_mul_gz0 (
        .clk (clk),
        .a   (s1_reg.g0),
        .b   (s1_reg.z),
        .p   (m2[0])
    );

    cpb_mul #(
        .A_W (AW),
        .B_W (CW)
    ) u_mul_gz1 (
        .clk (clk),
        .a   (s1_reg.g1),
        .b   (s1_reg.z),
        .p   (m2[1])
    );

    always_ff @(posedge clk)
    begin
        d2_reg[0] <= s1_reg;
        for (int i = 1; i < MUL_LAT; i++)
        begin
            d2_reg[i] <= d2_reg[i-1];
        end
    end

    always_comb
    begin
        s2_next.cmd = d2_reg[MUL_LAT-1].cmd;
        s2_next.n0  = d2_reg[MUL_LAT-1].n0;
        s2_next.n1  = d2_reg[MUL_LAT-1].n1;
        s2_next.n2  = d2_reg[MUL_LAT-1].n2;
        s2_next.a   = d2_reg[MUL_LAT-1].a;
        s2_next.b   = d2_reg[MUL_LAT-1].b;
        s2_next.c   = d2_reg[MUL_LAT-1].c;
        s2_next.d   = d2_reg[MUL_LAT-1].d;
        s2_next.e   = d2_reg[MUL_LAT-1].he - EW'(m2[0]);
        s2_next.f   = d2_reg[MUL_LAT-1].hf - EW'(m2[1]);
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
    end

    // ---------------------------------------------------------------
    // layer 3: determinant and Cramer numerators
    // ---------------------------------------------------------------
    cpb_mul #(.A_W(AW), .B_W(AW)) u_mul_ad
    (
        .clk (clk), .a (s2_reg.a), .b (s2_reg.d), .p (m_ad)
    );

    cpb_mul #(.A_W(AW), .B_W(AW)) u_mul_bc
    (
        .clk (clk), .a (s2_reg.b), .b (s2_reg.c), .p (m_bc)
    );

    cpb_mul #(.A_W(EW), .B_W(AW)) u_mul_ed
    (
        .clk (clk), .a (s2_reg.e), .b (s2_reg.d), .p (m_ed)
    );

    cpb_mul #(.A_W(EW), .B_W(AW)) u_mul_fb
    (
        .clk (clk), .a (s2_reg.f), .b (s2_reg.b), .p (m_fb)
    );

    cpb_mul #(.A_W(EW), .B_W(AW)) u_mul_fa
    (
        .clk (clk), .a (s2_reg.f), .b (s2_reg.a), .p (m_fa)
    );

    cpb_mul #(.A_W(EW), .B_W(AW)) u_mul_ec
    (
        .clk (clk), .a (s2_reg.e), .b (s2_reg.c), .p (m_ec)
    );

    always_ff @(posedge clk)
    begin
        d3_reg[0] <= s2_reg;
        for (int i = 1; i < MUL_LAT; i++)
        begin
            d3_reg[i] <= d3_reg[i-1];
        end
    end

    always_comb
    begin
        s3_next.cmd = d3_reg[MUL_LAT-1].cmd;
        s3_next.n0  = d3_reg[MUL_LAT-1].n0;
        s3_next.n1  = d3_reg[MUL_LAT-1].n1;
        s3_next.n2  = d3_reg[MUL_LAT-1].n2;
        s3_next.det = DW'(m_ad) - DW'(m_bc);
        s3_next.nx  = NW'(m_ed) - NW'(m_fb);
        s3_next.ny  = NW'(m_fa) - NW'(m_ec);
    end

    always_ff @(posedge clk)
    begin
        s3_reg <= s3_next;
    end

    // ---------------------------------------------------------------
    // pick the division for the command; project scales by 2^16 so the
    // quotient lands in Q16.16
    // ---------------------------------------------------------------
    always_comb
    begin
        if (s3_reg.cmd == CMD_BACKPROJECT)
        begin
            den_next  = s3_reg.det;
            numx_next = s3_reg.nx;
            numy_next = s3_reg.ny;
        end
        else
        begin
            den_next  = DW'(s3_reg.n2);
            numx_next = NW'(s3_reg.n0) <<< FRAC_SHIFT;
            numy_next = NW'(s3_reg.n1) <<< FRAC_SHIFT;
        end
        zero_next = (den_next == '0);
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= den_next;
        numx_reg <= numx_next;
        numy_reg <= numy_next;
        zero_reg <= zero_next;
    end

    // ---------------------------------------------------------------
    // divider, clamp and result register
    // ---------------------------------------------------------------
    cpb_div #(
        .NUM_W (NW),
        .DEN_W (DW),
        .QUO_W (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .vld   (vld_reg[TOT-1]),
        .zero  (zero_reg),
        .num_a (numx_reg),
        .num_b (numy_reg),
        .den   (den_reg),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

FILE: src/cpb_checker.sv
`timescale 1ns / 1ps

module cpb_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input cpb_pkg::rsp_t rsp
);
    import cpb_pkg::*;

    localparam int LAT = 3 * MUL_LAT + COORD_WIDTH + 7;

    // every result traces back to a request a fixed time earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching request");

    // every request yields its result
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("request dropped");

    // singular or zero denominator clears both results
    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STATUS_ZERO) |-> (rsp.result_a == '0 && rsp.result_b == '0))
        else $error("nonzero result on singular case");

endmodule

bind camera_project_and_plane_backproject cpb_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_cpb_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cpb_pkg::*;

    // wide signed arithmetic for the exact intermediates of the solve
    typedef logic signed [255:0] wide_t;

    localparam int LATENCY     = 51;
    localparam int SETTLE      = LATENCY + 10;
    localparam int STALL_LIMIT = 5000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    req_t               req;
    logic               done;
    rsp_t               rsp;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [REG_W-1:0]   wr_data;

    camera_project_and_plane_backproject dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data)
    );

    // shadow copy of the matrix registers, updated on every write
    logic [REG_W-1:0] matrix_shadow [NUM_REGS];

    // predicted results, oldest first
    rsp_t pending_rsp [$];

    int errors;
    int requests_sent;
    int results_seen;
    int zero_seen;
    int sat_seen;
    int idle_cycles;
    int burst_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // coefficient (row, col) as a signed Q20.12 value
    function automatic wide_t coef_at(input int row, input int col);
        logic [REG_W-1:0]          word;
        logic signed [HALF_W-1:0]  half;
        wide_t                     v;
        begin
            word = matrix_shadow[row * 2 + col / 2];
            half = (col % 2 == 1) ? word[REG_W-1:HALF_W] : word[HALF_W-1:0];
            v = half;
            return v;
        end
    endfunction

    // clamp a quotient to the 32-bit signed result range
    function automatic logic signed [RES_W-1:0] clamp_q(input wide_t q, inout logic over);
        wide_t hi;
        wide_t lo;
        begin
            hi = 64'sh7FFF_FFFF;
            lo = -hi - 1;
            if (q > hi)
            begin
                over = 1'b1;
                return hi[RES_W-1:0];
            end
            if (q < lo)
            begin
                over = 1'b1;
                return lo[RES_W-1:0];
            end
            return q[RES_W-1:0];
        end
    endfunction

    function automatic rsp_t predict_point(input req_t r);
        rsp_t  o;
        wide_t xv [4];
        wide_t n0, n1, n2;
        wide_t x, y, z;
        wide_t a, b, c, d, g0, g1, e, f, det;
        logic  over;
        begin
            over = 1'b0;
            o.result_a = '0;
            o.result_b = '0;
            o.status = STATUS_ZERO;
            if (r.cmd == CMD_PROJECT)
            begin
                xv[0] = r.coord_a;
                xv[1] = r.coord_b;
                xv[2] = r.coord_c;
                xv[3] = r.coord_w;
                n0 = 0;
                n1 = 0;
                n2 = 0;
                for (int k = 0; k < 4; k++)
                begin
                    n0 = n0 + coef_at(0, k) * xv[k];
                    n1 = n1 + coef_at(1, k) * xv[k];
                    n2 = n2 + coef_at(2, k) * xv[k];
                end
                if (n2 == 0)
                    return o;
                o.result_a = clamp_q((n0 <<< FRAC_SHIFT) / n2, over);
                o.result_b = clamp_q((n1 <<< FRAC_SHIFT) / n2, over);
            end
            else
            begin
                // coord_w plays no part in the plane solve
                x = r.coord_a;
                y = r.coord_b;
                z = r.coord_c;
                a  = x * coef_at(2, 0) - (coef_at(0, 0) <<< FRAC_SHIFT);
                b  = x * coef_at(2, 1) - (coef_at(0, 1) <<< FRAC_SHIFT);
                c  = y * coef_at(2, 0) - (coef_at(1, 0) <<< FRAC_SHIFT);
                d  = y * coef_at(2, 1) - (coef_at(1, 1) <<< FRAC_SHIFT);
                g0 = x * coef_at(2, 2) - (coef_at(0, 2) <<< FRAC_SHIFT);
                g1 = y * coef_at(2, 2) - (coef_at(1, 2) <<< FRAC_SHIFT);
                e = -(g0 * z) - ((x * coef_at(2, 3)) <<< FRAC_SHIFT)
                    + (coef_at(0, 3) <<< TERM_SHIFT);
                f = -(g1 * z) - ((y * coef_at(2, 3)) <<< FRAC_SHIFT)
                    + (coef_at(1, 3) <<< TERM_SHIFT);
                det = a * d - b * c;
                if (det == 0)
                    return o;
                o.result_a = clamp_q((e * d - b * f) / det, over);
                o.result_b = clamp_q((a * f - e * c) / det, over);
            end
            o.status = over ? STATUS_SAT : STATUS_OK;
            return o;
        end
    endfunction

    // ------------------------------------------------------------------
    // result checker and watchdog
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_rsp.size() == 0)
            begin
                $error("result with no pending request: a=%0d b=%0d status=%0d",
                       rsp.result_a, rsp.result_b, rsp.status);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (want.status == STATUS_ZERO)
                    zero_seen++;
                if (want.status == STATUS_SAT)
                    sat_seen++;
                if (rsp.result_a !== want.result_a)
                begin
                    $error("result_a expected %0d actual %0d", want.result_a, rsp.result_a);
                    errors++;
                end
                if (rsp.result_b !== want.result_b)
                begin
                    $error("result_b expected %0d actual %0d", want.result_b, rsp.result_b);
                    errors++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, rsp.status);
                    errors++;
                end
            end
        end
    end

    // counts cycles in which neither a request nor a result moves
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // writes all six matrix registers back to back; block must be idle
    task automatic write_matrix(input logic [REG_W-1:0] m0, input logic [REG_W-1:0] m1,
                                input logic [REG_W-1:0] m2, input logic [REG_W-1:0] m3,
                                input logic [REG_W-1:0] m4, input logic [REG_W-1:0] m5);
        logic [REG_W-1:0] vals [NUM_REGS];
        begin
            vals[0] = m0;
            vals[1] = m1;
            vals[2] = m2;
            vals[3] = m3;
            vals[4] = m4;
            vals[5] = m5;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                wr_en   <= 1'b1;
                wr_idx  <= i[IDX_W-1:0];
                wr_data <= vals[i];
                @(posedge clk);
                matrix_shadow[i] = vals[i];
            end
            wr_en <= 1'b0;
            @(posedge clk);
        end
    endtask

    // two Q20.12 coefficients into one register word
    function automatic logic [REG_W-1:0] pack_pair(input int even_col, input int odd_col);
        return {odd_col[HALF_W-1:0], even_col[HALF_W-1:0]};
    endfunction

    // sends one request; random bursts and gaps when shaping is on
    task automatic send_request(input req_t item, input bit shaped);
        int gap;
        begin
            if (shaped)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap > 0)
                    begin
                        start <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                burst_left--;
            end
            start <= 1'b1;
            req   <= item;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            pending_rsp.insert(pending_rsp.size(), predict_point(item));
            requests_sent++;
        end
    endtask

    // lowers start and waits for every pending result, then lets the pipe settle
    task automatic drain_results();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending_rsp.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    function automatic req_t make_req(input cmd_t cmd, input int a, input int b,
                                      input int c, input int w);
        req_t r;
        begin
            r.cmd = cmd;
            r.coord_a = a;
            r.coord_b = b;
            r.coord_c = c;
            r.coord_w = w;
            return r;
        end
    endfunction

    // coordinate picker: mostly plausible Q16.16 values, some raw and edge values
    function automatic int pick_coord(input int span);
        int sel;
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1:    return $urandom;
                2:       return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                3:       return $urandom_range(0, 3) - 1;
                default: return ($urandom_range(0, 2 * span) - span) * 65536
                                + $urandom_range(0, 65535);
            endcase
        end
    endfunction

    task automatic send_random(input int count, input int span);
        req_t item;
        int   w;
        begin
            for (int i = 0; i < count; i++)
            begin
                // homogeneous weight is usually one, sometimes anything
                w = ($urandom_range(0, 3) == 0) ? pick_coord(span) : 65536;
                item = make_req($urandom_range(0, 1) ? CMD_BACKPROJECT : CMD_PROJECT,
                                pick_coord(span), pick_coord(span), pick_coord(span), w);
                send_request(item, 1'b1);
                // one mid-stream pause until the pipe is empty
                if (i == count / 2)
                    drain_results();
            end
        end
    endtask

    // camera-like matrix: focal length, principal point and translation in Q20.12
    task automatic load_camera(input int fx, input int fy, input int cx, input int cy,
                               input int tx, input int ty, input int tz);
        begin
            write_matrix(pack_pair(fx * 4096, 0), pack_pair(cx * 4096, tx * 4096),
                         pack_pair(0, fy * 4096), pack_pair(cy * 4096, ty * 4096),
                         pack_pair(0, 4096),      pack_pair(4096, tz * 4096));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // matrix is all zero out of reset: every request hits the zero case
    task automatic test_reset_matrix();
        begin
            send_request(make_req(CMD_PROJECT, 65536, 65536, 65536, 65536), 1'b0);
            send_request(make_req(CMD_BACKPROJECT, 100 * 65536, 50 * 65536, 0, 0), 1'b0);
            drain_results();
        end
    endtask

    task automatic test_project_directed();
        begin
            load_camera(500, 500, 320, 240, 0, 0, 5);
            send_request(make_req(CMD_PROJECT, 0, 0, 0, 65536), 1'b0);
            send_request(make_req(CMD_PROJECT, 65536, -65536, 10 * 65536, 65536), 1'b0);
            send_request(make_req(CMD_PROJECT, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0);
            send_request(make_req(CMD_PROJECT, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000), 1'b0);
            // point at x = 3, y = 2, z = -5: depth y + z + tz stays nonzero with this row 2
            send_request(make_req(CMD_PROJECT, 3 * 65536, 2 * 65536, -5 * 65536, 65536), 1'b0);
            // large opposite x and y, z just above -5: depth y + z + tz is near -1000
            send_request(make_req(CMD_PROJECT, 1000 * 65536, -1000 * 65536,
                                  -5 * 65536 + 1, 65536), 1'b0);
            send_request(make_req(CMD_PROJECT, -7 * 65536, 9 * 65536, 3 * 65536, -65536), 1'b0);
            drain_results();
        end
    endtask

    task automatic test_backproject_directed();
        begin
            load_camera(600, 550, 320, 240, 1, -2, 8);
            send_request(make_req(CMD_BACKPROJECT, 320 * 65536, 240 * 65536, 0, 0), 1'b0);
            send_request(make_req(CMD_BACKPROJECT, 0, 0, 65536, 32'h7FFF_FFFF), 1'b0);
            send_request(make_req(CMD_BACKPROJECT, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 0), 1'b0);
            send_request(make_req(CMD_BACKPROJECT, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000), 1'b0);
            send_request(make_req(CMD_BACKPROJECT, -1, 1, -1, 0), 1'b0);
            drain_results();
            // rank-deficient plane system: singular for every pixel
            write_matrix(pack_pair(4096, 4096), pack_pair(4096, 0),
                         pack_pair(8192, 8192), pack_pair(0, 4096),
                         pack_pair(0, 0),       pack_pair(4096, 4096));
            send_request(make_req(CMD_BACKPROJECT, 5 * 65536, 7 * 65536, 65536, 0), 1'b0);
            send_request(make_req(CMD_PROJECT, 65536, 65536, 65536, 65536), 1'b0);
            drain_results();
        end
    endtask

    // rows 0 and 1 at the largest coefficient magnitudes drive the projection into clamping
    task automatic test_extreme_matrix();
        begin
            write_matrix(64'h8000_0000_7FFF_FFFF, 64'h7FFF_FFFF_8000_0000,
                         64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000,
                         64'h0000_0001_FFFF_FFFF, 64'hFFFF_FFFF_0000_0001);
            send_request(make_req(CMD_PROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 65536), 1'b0);
            send_request(make_req(CMD_BACKPROJECT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0), 1'b0);
            send_request(make_req(CMD_PROJECT, 1, 0, 0, 0), 1'b0);
            drain_results();
            send_random(60, 1000);
            drain_results();
        end
    endtask

    task automatic test_random_cameras();
        begin
            for (int p = 0; p < 4; p++)
            begin
                load_camera($urandom_range(100, 2000), $urandom_range(100, 2000),
                            $urandom_range(0, 1920), $urandom_range(0, 1080),
                            $urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10,
                            $urandom_range(1, 50));
                send_random(80, 2000);
                drain_results();
            end
        end
    endtask

    task automatic test_random_matrices();
        begin
            write_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
            send_random(70, 30000);
            drain_results();
        end
    endtask

    initial
    begin
        errors        = 0;
        requests_sent = 0;
        results_seen  = 0;
        zero_seen     = 0;
        sat_seen      = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        for (int i = 0; i < NUM_REGS; i++)
            matrix_shadow[i] = '0;
        rst_n   = 1'b0;
        start   = 1'b0;
        req     = '0;
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_matrix();
        test_project_directed();
        test_backproject_directed();
        test_extreme_matrix();
        test_random_cameras();
        test_random_matrices();
        drain_results();

        $display("ran %0d requests, checked %0d results (%0d zero-denominator, %0d clamped)",
                 requests_sent, results_seen, zero_seen, sat_seen);
        $display("covered projection and plane solves over camera, random and extreme matrices");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
src/cpb_pkg.sv
src/cpb_mul.sv
src/cpb_div.sv
src/camera_project_and_plane_backproject.sv
src/cpb_checker.sv
tb/tb_top.sv
